// ===== rtl/spectrum_bar_gravity_smoother_core_assert.svh =====
// Assertion macros for the spectrum bar gravity smoother.
// Included by the checker; no other dependencies.
`ifndef SPECTRUM_BAR_GRAVITY_SMOOTHER_CORE_ASSERT_SVH
`define SPECTRUM_BAR_GRAVITY_SMOOTHER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define SBGS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define SBGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/sbgs_pkg.sv =====
// Shared types, constants and helpers for the spectrum bar gravity smoother.
// No dependencies.
package sbgs_pkg;

    localparam int NUM_BARS_DEF = 256;
    localparam int IDX_W        = 8;
    localparam int LVL_W        = 32;
    localparam int FALL_W       = 16;

    localparam logic [31:0] ONE_Q16        = 32'h0001_0000;
    localparam logic [15:0] FALL_STEP      = 16'd918;
    localparam logic [15:0] FALL_MAX       = 16'd32768;
    localparam logic [15:0] NR_GRAVITY_MIN = 16'd6554;
    localparam logic [31:0] SILENCE_FLOOR  = 32'd66;
    localparam logic [31:0] SENS_FALL      = 32'd64225;
    localparam logic [31:0] SENS_RISE      = 32'd65602;
    localparam logic [31:0] SENS_RESET     = 32'd6553600;
    localparam logic [15:0] GRAV_ONE       = 16'd256;
    localparam logic [15:0] NR_RESET       = 16'd50463;
    localparam logic [31:0] SCALE_RESET    = 32'h0001_0000;

    typedef enum logic [1:0] {
        CFG_AUTOSENS  = 2'd0,
        CFG_NOISE_RED = 2'd1,
        CFG_GRAVITY   = 2'd2,
        CFG_SCALE     = 2'd3
    } cfg_idx_t;

    // One entry of the per-bar state memory.
    typedef struct packed {
        logic [LVL_W-1:0]  peak;
        logic [FALL_W-1:0] fall;
        logic [LVL_W-1:0]  prev;
        logic [LVL_W-1:0]  smooth;
    } bar_state_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

// ===== rtl/sbgs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sbgs_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on nothing but its operands.
module sbgs_mul (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 64'(a) * 64'(b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/spectrum_bar_gravity_smoother_core.sv =====
// Top level of the spectrum bar gravity smoother: sequencer, registers, datapath.
// Depends on sbgs_pkg, sbgs_ram and sbgs_mul.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+-------------------
//  input   | s_bar_index s_bar_level s_signal_present ... | s_valid / s_ready
//  result  | m_out_index m_out_level m_out_frame_end      | m_valid / m_ready
//  config  | cfg_index cfg_data                           | cfg_we, no wait
//
// One item at a time: a transfer runs LOAD, SENS, G1, SM1-SM3, POST, SCALE and
// OUT before the next, plus G2-G4 when the bar falls under gravity and SA1-SA2
// on a frame end that adapts the sensitivity. The shared multiplier sets this order.
// After reset a clearing pass writes all NUM_BARS memory entries, one per
// cycle; s_ready stays low meanwhile. A stalled result waits in the output
// register; the sequencer holds its last step until that register is free.
module spectrum_bar_gravity_smoother_core
    import sbgs_pkg::*;
#(
    parameter int NUM_BARS = NUM_BARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_bar_index,
    input  logic [31:0] s_bar_level,
    input  logic        s_signal_present,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_index,
    output logic [31:0] m_out_level,
    output logic        m_out_frame_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ADDR_W = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int ST_W   = $bits(bar_state_t);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_SENS, ST_G1, ST_G2, ST_G3, ST_G4,
        ST_SM1, ST_SM2, ST_SM3, ST_POST, ST_SCALE, ST_OUT, ST_SA1, ST_SA2
    } state_t;

    state_t state_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // configuration
    logic        autosens_reg;
    logic [15:0] nr_reg;
    logic [15:0] gfac_reg;
    logic [31:0] scale_reg;

    // global sensitivity state
    logic [31:0] sens_reg;
    logic        first_rise_reg;
    logic [1:0]  frame_cnt_reg;
    logic        overshoot_reg;
    logic        sa_fall_reg;

    // item in flight
    logic [7:0]        idx_reg;
    logic [31:0]       lvl_in_reg;
    logic              sig_reg;
    logic              fend_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [31:0]       v_reg;
    logic              pzero_reg;
    logic [30:0]       f_reg;
    logic [31:0]       lvl_reg;
    logic [31:0]       new_peak_reg;
    logic [15:0]       new_fall_reg;
    logic [47:0]       acc_reg;
    logic [31:0]       s_reg;
    logic [31:0]       post_reg;

    // result register
    logic        m_valid_reg;
    logic [7:0]  m_index_reg;
    logic [31:0] m_level_reg;
    logic        m_fend_reg;

    // bar index to memory address, folded at elaboration
    logic [ADDR_W-1:0] mod_tab [256];
    for (genvar i = 0; i < 256; i++) begin : g_mod
        assign mod_tab[i] = ADDR_W'(i % NUM_BARS);
    end

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ST_W-1:0]   ram_rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ST_W-1:0]   wr_data;
    bar_state_t        rd_state;
    bar_state_t        wb_state;

    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    logic        in_xfer;
    logic        out_free;
    logic        sa_go;
    logic [15:0] g_eff;
    logic [31:0] v_comb;
    logic        grav_comb;
    logic [38:0] f_diff;
    logic [16:0] fall_sum;
    logic [15:0] fall_next;
    logic [49:0] sm_sum;
    logic [31:0] s_comb;
    logic [31:0] floor_lvl;
    logic        clamp_hit;
    logic [31:0] rise_lvl;
    logic [31:0] rise_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = in_xfer;
    assign rd_addr  = mod_tab[s_bar_index];
    assign rd_state = bar_state_t'(ram_rd_data);

    // every third frame end with autosens on adapts, if there is anything to adapt to
    assign sa_go = fend_reg && autosens_reg && (frame_cnt_reg == 2'd2)
                   && (overshoot_reg || sig_reg);

    assign g_eff = (gfac_reg < GRAV_ONE) ? GRAV_ONE : gfac_reg;

    assign v_comb    = autosens_reg ? sat32({16'b0, prod[63:16]}) : lvl_in_reg;
    assign grav_comb = (v_reg < rd_state.prev) && (nr_reg >= NR_GRAVITY_MIN);
    // when p < 2^38 the difference is at most 2^38; a larger p sets pzero_reg instead
    assign f_diff    = {1'b1, 38'b0} - prod[38:0];
    assign fall_sum  = 17'(rd_state.fall) + 17'(FALL_STEP);
    assign fall_next = (fall_sum > 17'(FALL_MAX)) ? FALL_MAX : fall_sum[15:0];
    assign sm_sum    = 50'(acc_reg) + 50'(prod[48:0]);
    assign s_comb    = sat32(64'(sm_sum[49:16]));
    assign floor_lvl = (!sig_reg && (s_reg < SILENCE_FLOOR)) ? SILENCE_FLOOR : s_reg;
    assign clamp_hit = autosens_reg && (floor_lvl > ONE_Q16);
    assign rise_lvl  = sat32({16'b0, prod[63:16]});
    assign rise_next = !first_rise_reg ? rise_lvl :
                       (rise_lvl[31] ? 32'hFFFF_FFFF : {rise_lvl[30:0], 1'b0});

    always_comb begin
        wb_state.peak   = new_peak_reg;
        wb_state.fall   = new_fall_reg;
        wb_state.prev   = lvl_reg;
        wb_state.smooth = floor_lvl;
        wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_POST);
        wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
        wr_data = (state_reg == ST_CLEAR) ? '0 : ST_W'(wb_state);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_LOAD: begin
                mul_a = lvl_in_reg;
                mul_b = sens_reg;
            end
            ST_SENS: begin
                mul_a = 32'(rd_state.fall);
                mul_b = 32'(rd_state.fall);
            end
            ST_G1: begin
                mul_a = prod[31:0];
                mul_b = 32'(g_eff);
            end
            ST_G3: begin
                mul_a = rd_state.peak;
                mul_b = 32'(f_reg);
            end
            ST_SM1: begin
                mul_a = rd_state.smooth;
                mul_b = 32'(nr_reg);
            end
            ST_SM2: begin
                mul_a = lvl_reg;
                mul_b = 32'(17'h1_0000 - 17'(nr_reg));
            end
            ST_SCALE: begin
                mul_a = post_reg;
                mul_b = scale_reg;
            end
            ST_SA1: begin
                mul_a = sens_reg;
                mul_b = sa_fall_reg ? SENS_FALL : SENS_RISE;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    sbgs_ram #(
        .WIDTH (ST_W),
        .DEPTH (NUM_BARS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    sbgs_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            autosens_reg   <= 1'b0;
            nr_reg         <= NR_RESET;
            gfac_reg       <= GRAV_ONE;
            scale_reg      <= SCALE_RESET;
            sens_reg       <= SENS_RESET;
            first_rise_reg <= 1'b1;
            frame_cnt_reg  <= '0;
            overshoot_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_AUTOSENS:  autosens_reg <= cfg_data[0];
                    CFG_NOISE_RED: nr_reg       <= cfg_data[15:0];
                    CFG_GRAVITY:   gfac_reg     <= cfg_data[15:0];
                    CFG_SCALE:     scale_reg    <= cfg_data;
                endcase
            end

            // ST_OUT reloads the result register itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(NUM_BARS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        idx_reg    <= s_bar_index;
                        lvl_in_reg <= s_bar_level;
                        sig_reg    <= s_signal_present;
                        fend_reg   <= s_frame_end;
                        addr_reg   <= rd_addr;
                        state_reg  <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_SENS;
                end
                ST_SENS: begin
                    v_reg     <= v_comb;
                    state_reg <= ST_G1;
                end
                ST_G1: begin
                    if (grav_comb) begin
                        state_reg <= ST_G2;
                    end else begin
                        // rising or no falloff: peak restarts here
                        lvl_reg      <= v_reg;
                        new_peak_reg <= v_reg;
                        new_fall_reg <= '0;
                        state_reg    <= ST_SM1;
                    end
                end
                ST_G2: begin
                    pzero_reg <= |prod[47:38];
                    f_reg     <= f_diff[38:8];
                    state_reg <= ST_G3;
                end
                ST_G3: begin
                    state_reg <= ST_G4;
                end
                ST_G4: begin
                    lvl_reg      <= pzero_reg ? '0 : prod[61:30];
                    new_peak_reg <= rd_state.peak;
                    new_fall_reg <= fall_next;
                    state_reg    <= ST_SM1;
                end
                ST_SM1: begin
                    state_reg <= ST_SM2;
                end
                ST_SM2: begin
                    acc_reg   <= prod[47:0];
                    state_reg <= ST_SM3;
                end
                ST_SM3: begin
                    s_reg     <= s_comb;
                    state_reg <= ST_POST;
                end
                ST_POST: begin
                    post_reg <= clamp_hit ? ONE_Q16 : floor_lvl;
                    if (clamp_hit) begin
                        overshoot_reg <= 1'b1;
                    end
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_index_reg <= idx_reg;
                        m_level_reg <= sat32({16'b0, prod[63:16]});
                        m_fend_reg  <= fend_reg;
                        state_reg   <= sa_go ? ST_SA1 : ST_IDLE;
                        if (fend_reg) begin
                            overshoot_reg <= 1'b0;
                            sa_fall_reg   <= overshoot_reg;
                            if (autosens_reg) begin
                                if (frame_cnt_reg == 2'd2) begin
                                    frame_cnt_reg <= '0;
                                end else begin
                                    frame_cnt_reg <= frame_cnt_reg + 2'd1;
                                end
                            end
                        end
                    end
                end
                ST_SA1: begin
                    state_reg <= ST_SA2;
                end
                ST_SA2: begin
                    if (sa_fall_reg) begin
                        sens_reg       <= prod[47:16];
                        first_rise_reg <= 1'b0;
                    end else begin
                        sens_reg <= rise_next;
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_index     = m_index_reg;
    assign m_out_level     = m_level_reg;
    assign m_out_frame_end = m_fend_reg;

endmodule

// ===== rtl/sbgs_checker.sv =====
// Port-level checker for the spectrum bar gravity smoother, bound to the top.
// Depends on spectrum_bar_gravity_smoother_core_assert.svh.
`include "spectrum_bar_gravity_smoother_core_assert.svh"

module sbgs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_index,
    input logic [31:0] m_out_level,
    input logic        m_out_frame_end
);

    // a stalled result transfer keeps its payload
    `SBGS_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_out_index) && $stable(m_out_level) && $stable(m_out_frame_end)), "result changed while stalled")

    // reset starts the clearing pass, so no input is taken right after it
    `SBGS_ASSERT_ALWAYS(a_clear_after_reset, aclk, (!aresetn) |=> (!s_ready), "input ready during clearing pass")

    // one item in flight: an input transfer closes the input side
    `SBGS_ASSERT(a_one_in_flight, aclk, aresetn, (s_valid && s_ready) |=> (!s_ready), "input ready right after a transfer")

endmodule

bind spectrum_bar_gravity_smoother_core sbgs_checker u_sbgs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_index     (m_out_index),
    .m_out_level     (m_out_level),
    .m_out_frame_end (m_out_frame_end)
);
